>>> design/kwp_pkg.sv
// shared codes and constants for the kwp frame receiver
package kwp_pkg;

    // format byte fields
    localparam logic [7:0] FMT_MODE_MASK = 8'hC0;
    localparam logic [7:0] FMT_CARB      = 8'h40;
    localparam logic [7:0] FMT_ADDR_BIT  = 8'h80;
    localparam logic [7:0] FMT_LEN_MASK  = 8'h3F;

    // frame status codes
    typedef enum logic [1:0] {
        ST_MORE = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    // byte role codes
    typedef enum logic [2:0] {
        ROLE_FMT  = 3'd0,
        ROLE_TGT  = 3'd1,
        ROLE_SRC  = 3'd2,
        ROLE_LEN  = 3'd3,
        ROLE_DATA = 3'd4,
        ROLE_CKS  = 3'd5
    } t_role;

endpackage

>>> design/kwp_frame_receiver_unit.sv
// kwp2000 frame receiver: byte framing, running sum and checksum check
// A result is valid the cycle after its byte is accepted. Throughput: one
// byte per cycle unless stalled; a byte's parse is a single pass of compare
// and 8-bit add logic between the frame state and the result register.
// Reset: synchronous, active low; clears the frame state and the result valid,
// after which the block waits for a format byte.
module kwp_frame_receiver_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [2:0] o_byte_role,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_payload_index,
    output logic [7:0] o_frame_length,
    output logic       o_has_addresses,
    output logic [7:0] o_target_addr,
    output logic [7:0] o_source_addr,
    output logic [7:0] o_computed_sum
);

    // frame state
    logic [2:0] r_hdr_pos,  n_hdr_pos;
    logic [2:0] r_hdr_len,  n_hdr_len;
    logic [7:0] r_data_len, n_data_len;
    logic [8:0] r_data_pos, n_data_pos;
    logic [7:0] r_sum,      n_sum;
    logic [7:0] r_tgt,      n_tgt;
    logic [7:0] r_src,      n_src;
    logic       r_addr,     n_addr;

    // result register
    logic                r_out_valid;
    kwp_pkg::t_status    r_status,   n_status;
    kwp_pkg::t_role      r_role,     n_role;
    logic [7:0]          r_byte;
    logic [7:0]          r_pidx,     n_pidx;
    logic [7:0]          r_len_out;
    logic                r_addr_out;
    logic [7:0]          r_tgt_out;
    logic [7:0]          r_src_out;
    logic [7:0]          r_sum_out,  n_sum_out;

    logic c_accept;
    logic c_clear;
    logic c_carb;

    // handshake: hold input only while a result is stuck
    assign o_stall  = r_out_valid & i_stall;
    assign c_accept = i_valid & ~o_stall;

    // parse one byte
    always_comb begin
        n_hdr_pos  = r_hdr_pos;
        n_hdr_len  = r_hdr_len;
        n_data_len = r_data_len;
        n_data_pos = r_data_pos;
        n_sum      = r_sum;
        n_tgt      = r_tgt;
        n_src      = r_src;
        n_addr     = r_addr;
        n_status   = kwp_pkg::ST_MORE;
        n_role     = kwp_pkg::ROLE_FMT;
        n_pidx     = 8'd0;
        n_sum_out  = r_sum;
        c_clear    = 1'b0;
        c_carb     = 1'b0;
        if (r_hdr_pos == 3'd0) begin
            n_role = kwp_pkg::ROLE_FMT;
            if ((i_rx_byte & kwp_pkg::FMT_MODE_MASK) == kwp_pkg::FMT_CARB) begin
                // carb mode: error, frame state cleared
                c_carb     = 1'b1;
                c_clear    = 1'b1;
                n_status   = kwp_pkg::ST_ERR;
                n_hdr_pos  = 3'd0;
                n_hdr_len  = 3'd0;
                n_data_len = 8'd0;
                n_data_pos = 9'd0;
                n_sum      = 8'd0;
                n_tgt      = 8'd0;
                n_src      = 8'd0;
                n_addr     = 1'b0;
                n_sum_out  = 8'd0;
            end else begin
                n_addr     = i_rx_byte[7];
                n_hdr_len  = 3'd1 + (i_rx_byte[7] ? 3'd2 : 3'd0)
                           + (((i_rx_byte & kwp_pkg::FMT_LEN_MASK) == 8'd0) ? 3'd1 : 3'd0);
                n_data_len = i_rx_byte & kwp_pkg::FMT_LEN_MASK;
                n_data_pos = 9'd0;
                n_tgt      = 8'd0;
                n_src      = 8'd0;
                n_hdr_pos  = 3'd1;
                n_sum      = i_rx_byte;
                n_sum_out  = i_rx_byte;
            end
        end else if (r_hdr_pos != r_hdr_len) begin
            // remaining header bytes
            if (r_addr && r_hdr_pos == 3'd1) begin
                n_role = kwp_pkg::ROLE_TGT;
                n_tgt  = i_rx_byte;
            end else if (r_addr && r_hdr_pos == 3'd2) begin
                n_role = kwp_pkg::ROLE_SRC;
                n_src  = i_rx_byte;
            end else begin
                n_role     = kwp_pkg::ROLE_LEN;
                n_data_len = i_rx_byte;
            end
            n_hdr_pos = r_hdr_pos + 3'd1;
            n_sum     = r_sum + i_rx_byte;
            n_sum_out = n_sum;
        end else if (r_data_pos < {1'b0, r_data_len}) begin
            // payload byte
            n_role     = kwp_pkg::ROLE_DATA;
            n_pidx     = r_data_pos[7:0];
            n_data_pos = r_data_pos + 9'd1;
            n_sum      = r_sum + i_rx_byte;
            n_sum_out  = n_sum;
        end else begin
            // checksum byte ends the frame
            n_role    = kwp_pkg::ROLE_CKS;
            n_status  = (i_rx_byte == r_sum) ? kwp_pkg::ST_DONE : kwp_pkg::ST_ERR;
            n_sum_out = r_sum;
            c_clear   = 1'b1;
        end
    end

    // frame state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos   <= 3'd0;
            r_hdr_len   <= 3'd0;
            r_data_len  <= 8'd0;
            r_data_pos  <= 9'd0;
            r_sum       <= 8'd0;
            r_tgt       <= 8'd0;
            r_src       <= 8'd0;
            r_addr      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (c_accept) begin
                if (c_clear) begin
                    r_hdr_pos  <= 3'd0;
                    r_hdr_len  <= 3'd0;
                    r_data_len <= 8'd0;
                    r_data_pos <= 9'd0;
                    r_sum      <= 8'd0;
                    r_tgt      <= 8'd0;
                    r_src      <= 8'd0;
                    r_addr     <= 1'b0;
                end else begin
                    r_hdr_pos  <= n_hdr_pos;
                    r_hdr_len  <= n_hdr_len;
                    r_data_len <= n_data_len;
                    r_data_pos <= n_data_pos;
                    r_sum      <= n_sum;
                    r_tgt      <= n_tgt;
                    r_src      <= n_src;
                    r_addr     <= n_addr;
                end
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_status   <= n_status;
            r_role     <= n_role;
            r_byte     <= i_rx_byte;
            r_pidx     <= n_pidx;
            r_len_out  <= c_carb ? 8'd0 : n_data_len;
            r_addr_out <= c_carb ? 1'b0 : n_addr;
            r_tgt_out  <= c_carb ? 8'd0 : n_tgt;
            r_src_out  <= c_carb ? 8'd0 : n_src;
            r_sum_out  <= n_sum_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_byte_role     = r_role;
    assign o_payload_byte  = r_byte;
    assign o_payload_index = r_pidx;
    assign o_frame_length  = r_len_out;
    assign o_has_addresses = r_addr_out;
    assign o_target_addr   = r_tgt_out;
    assign o_source_addr   = r_src_out;
    assign o_computed_sum  = r_sum_out;

endmodule

>>> design/kwp_checker.sv
// port-level checks for the kwp frame receiver, bound to the top level
module kwp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic [2:0] o_byte_role,
    input logic [7:0] o_payload_byte,
    input logic [7:0] o_payload_index,
    input logic [7:0] o_frame_length,
    input logic [7:0] o_computed_sum
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_payload_byte) && $stable(o_status))
        else $error("stalled result changed");

    // index only counts on payload bytes
    a_pidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_role != kwp_pkg::ROLE_DATA |-> o_payload_index == 8'd0)
        else $error("payload index set outside payload");

    // frame end only on format or checksum bytes
    a_end_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != kwp_pkg::ST_MORE
        |-> o_byte_role == kwp_pkg::ROLE_FMT || o_byte_role == kwp_pkg::ROLE_CKS)
        else $error("frame end on a header or payload byte");

    // carb error reports a cleared frame
    a_carb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == kwp_pkg::ST_ERR && o_byte_role == kwp_pkg::ROLE_FMT
        |-> o_frame_length == 8'd0 && o_computed_sum == 8'd0)
        else $error("carb error with frame fields set");

    // good frame means checksum matches the sum
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == kwp_pkg::ST_DONE |-> o_computed_sum == o_payload_byte)
        else $error("good frame with checksum mismatch");

endmodule

bind kwp_frame_receiver_unit kwp_checker u_kwp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_byte_role    (o_byte_role),
    .o_payload_byte (o_payload_byte),
    .o_payload_index(o_payload_index),
    .o_frame_length (o_frame_length),
    .o_computed_sum (o_computed_sum)
);

>>> bench/kwp_frame_receiver_unit_tb.sv
// testbench for the kwp2000 frame receiver: framed and noisy byte traffic checked per byte
`timescale 1ns / 1ps

module kwp_frame_receiver_unit_tb;

    // one parse result as seen on the output ports
    typedef struct packed {
        kwp_pkg::t_status status;
        kwp_pkg::t_role   role;
        logic [7:0]       payload_byte;
        logic [7:0]       payload_index;
        logic [7:0]       frame_length;
        logic             has_addresses;
        logic [7:0]       target_addr;
        logic [7:0]       source_addr;
        logic [7:0]       computed_sum;
    } t_rx_result;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_status;
    logic [2:0] o_byte_role;
    logic [7:0] o_payload_byte;
    logic [7:0] o_payload_index;
    logic [7:0] o_frame_length;
    logic       o_has_addresses;
    logic [7:0] o_target_addr;
    logic [7:0] o_source_addr;
    logic [7:0] o_computed_sum;

    // parser model state
    logic [2:0] hdr_pos;
    logic [2:0] hdr_len;
    logic [7:0] data_len;
    logic [8:0] data_pos;
    logic [7:0] sum_acc;
    logic [7:0] tgt_reg;
    logic [7:0] src_reg;
    logic       addr_seen;

    t_rx_result pending_rx_results[$];
    logic [7:0] frame_data[$];
    int         fail_count    = 0;
    int         bytes_sent    = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_len      = 0;

    kwp_frame_receiver_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_byte_role     (o_byte_role),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_frame_length  (o_frame_length),
        .o_has_addresses (o_has_addresses),
        .o_target_addr   (o_target_addr),
        .o_source_addr   (o_source_addr),
        .o_computed_sum  (o_computed_sum)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // back to waiting for a format byte
    function automatic void clear_frame();
        hdr_pos   = 3'd0;
        hdr_len   = 3'd0;
        data_len  = 8'd0;
        data_pos  = 9'd0;
        sum_acc   = 8'd0;
        tgt_reg   = 8'd0;
        src_reg   = 8'd0;
        addr_seen = 1'b0;
    endfunction

    // give one received byte its role and advance the frame state
    function automatic t_rx_result parse_byte(input logic [7:0] b);
        t_rx_result r;
        logic       frame_end;
        r               = '0;
        r.status        = kwp_pkg::ST_MORE;
        r.payload_byte  = b;
        r.payload_index = 8'd0;
        frame_end       = 1'b0;
        if (hdr_pos == 3'd0) begin
            r.role = kwp_pkg::ROLE_FMT;
            // carb mode format: error and nothing else reported
            if ((b & kwp_pkg::FMT_MODE_MASK) == kwp_pkg::FMT_CARB) begin
                clear_frame();
                r.status = kwp_pkg::ST_ERR;
                return r;
            end
            clear_frame();
            hdr_len = 3'd1;
            if ((b & kwp_pkg::FMT_ADDR_BIT) != 8'd0) begin
                addr_seen = 1'b1;
                hdr_len   = hdr_len + 3'd2;
            end
            if ((b & kwp_pkg::FMT_LEN_MASK) == 8'd0) begin
                hdr_len = hdr_len + 3'd1;
            end else begin
                data_len = b & kwp_pkg::FMT_LEN_MASK;
            end
            hdr_pos        = 3'd1;
            sum_acc        = b;
            r.computed_sum = sum_acc;
        end else if (hdr_pos != hdr_len) begin
            // address and length bytes
            if (addr_seen && hdr_pos == 3'd1) begin
                r.role  = kwp_pkg::ROLE_TGT;
                tgt_reg = b;
            end else if (addr_seen && hdr_pos == 3'd2) begin
                r.role  = kwp_pkg::ROLE_SRC;
                src_reg = b;
            end else begin
                r.role   = kwp_pkg::ROLE_LEN;
                data_len = b;
            end
            hdr_pos        = hdr_pos + 3'd1;
            sum_acc        = sum_acc + b;
            r.computed_sum = sum_acc;
        end else if (data_pos < {1'b0, data_len}) begin
            r.role          = kwp_pkg::ROLE_DATA;
            r.payload_index = data_pos[7:0];
            data_pos        = data_pos + 9'd1;
            sum_acc         = sum_acc + b;
            r.computed_sum  = sum_acc;
        end else begin
            // checksum compared against the sum so far
            r.role         = kwp_pkg::ROLE_CKS;
            r.computed_sum = sum_acc;
            r.status       = (b == sum_acc) ? kwp_pkg::ST_DONE : kwp_pkg::ST_ERR;
            frame_end      = 1'b1;
        end
        r.frame_length  = data_len;
        r.has_addresses = addr_seen;
        r.target_addr   = tgt_reg;
        r.source_addr   = src_reg;
        if (frame_end) begin
            clear_frame();
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // receiver side: random stall, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            i_stall  <= 1'b1;
            hold_len = hold_len - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_rx_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rx_results.size() == 0) begin
                $error("result with no request outstanding: role %0d byte %0d",
                       o_byte_role, o_payload_byte);
                fail_count++;
            end else begin
                exp_r = pending_rx_results.pop_front();
                check_field("status", exp_r.status, o_status);
                check_field("byte_role", exp_r.role, o_byte_role);
                check_field("payload_byte", exp_r.payload_byte, o_payload_byte);
                check_field("payload_index", exp_r.payload_index, o_payload_index);
                check_field("frame_length", exp_r.frame_length, o_frame_length);
                check_field("has_addresses", exp_r.has_addresses, o_has_addresses);
                check_field("target_addr", exp_r.target_addr, o_target_addr);
                check_field("source_addr", exp_r.source_addr, o_source_addr);
                check_field("computed_sum", exp_r.computed_sum, o_computed_sum);
            end
        end
    end

    // offer one byte, wait for acceptance, record the prediction
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pending_rx_results.push_back(parse_byte(b));
        bytes_sent++;
    endtask

    // one frame built from its header fields and frame_data, checksum optionally corrupted
    task automatic send_frame(input logic [7:0] fmt, input logic [7:0] tgt,
                              input logic [7:0] src, input logic [7:0] len_byte,
                              input logic [7:0] cks_xor);
        logic [7:0] cks;
        cks = fmt;
        send_byte(fmt);
        if (fmt[7]) begin
            send_byte(tgt);
            send_byte(src);
            cks = cks + tgt + src;
        end
        if (fmt[5:0] == 6'd0) begin
            send_byte(len_byte);
            cks = cks + len_byte;
        end
        foreach (frame_data[k]) begin
            send_byte(frame_data[k]);
            cks = cks + frame_data[k];
        end
        send_byte(cks ^ cks_xor);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (pending_rx_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_rx_results.size() != 0) begin
            $error("%0d results never arrived", pending_rx_results.size());
            fail_count++;
        end
    endtask

    task automatic test_carb_format();
        send_byte(8'h40);
        send_byte(8'h7F);
    endtask

    task automatic test_plain_frame();
        frame_data = '{8'hFF, 8'h00};
        send_frame(8'h02, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_address_frame();
        frame_data = '{8'hAA};
        send_frame(8'h81, 8'h00, 8'hFF, 8'h00, 8'h00);
    endtask

    task automatic test_zero_length();
        frame_data = {};
        send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_bad_checksum();
        frame_data = '{8'h55};
        send_frame(8'hC0, 8'h12, 8'h34, 8'h01, 8'h80);
        frame_data = '{8'hFF};
        send_frame(8'h01, 8'h00, 8'h00, 8'h00, 8'hFF);
    endtask

    // one random frame, mostly short and well formed, its checksum now and then corrupted
    task automatic send_random_frame();
        int         len;
        logic [7:0] fmt;
        logic [7:0] cks_xor;
        bit         use_len_byte;
        if ($urandom_range(59) == 0) begin
            len = $urandom_range(255);
        end else begin
            len = $urandom_range(8);
        end
        use_len_byte = (len == 0) || (len > 63) || ($urandom_range(1) == 1);
        case ($urandom_range(2))
            0: fmt = 8'h00;
            1: fmt = 8'h80;
            default: fmt = 8'hC0;
        endcase
        if (!use_len_byte) begin
            fmt[5:0] = len[5:0];
        end
        cks_xor = ($urandom_range(6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        frame_data = {};
        repeat (len) frame_data.push_back(8'($urandom_range(255)));
        send_frame(fmt, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'(len), cks_xor);
    endtask

    // mostly frames, with carb bytes and line noise in between
    task automatic test_random_traffic(input int n);
        int stop_at;
        int pick;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at) begin
            // finish whatever frame noise left open
            while (hdr_pos != 3'd0) begin
                send_byte(8'($urandom_range(255)));
            end
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_random_frame();
            end else if (pick < 85) begin
                send_byte(8'h40 | 8'($urandom_range(63)));
            end else begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_receiver_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 150;
        repeat (4) send_random_frame();
        drain_results();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clear_frame();
        @(posedge i_clk);

        test_carb_format();
        test_plain_frame();
        test_address_frame();
        test_zero_length();
        test_bad_checksum();
        drain_results();

        // idling phases: none, sender, receiver, both
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_traffic(125);
        send_idle_pct = 71; recv_stall_pct = 0;
        test_random_traffic(125);
        drain_results();
        send_idle_pct = 0;  recv_stall_pct = 71;
        test_random_traffic(125);
        send_idle_pct = 25; recv_stall_pct = 25;
        test_random_traffic(125);

        test_receiver_holdoff();
        drain_results();
        repeat (5) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
